### src/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants for the indexed sequential list
// Operation and status codes, field widths, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int unsigned CAPACITY_DEF = 128;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned LEN_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the request
        logic decode;  // check the request, set up the scan index
        logic step;    // issue the next store read of a shift or a search
        logic put;     // write the inserted value at its position
        logic fetch;   // read the store at the requested position
        logic grab;    // keep the word fetched for a read
        logic hit;     // record the matching index
        logic miss;    // record a failed search
        logic emit;    // load the result register, update the length
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic err;       // request rejected
        logic more;      // another store read is due
        logic hit;       // word under compare matches the search value
        logic rpend;     // a search read is in flight
        logic wpend;     // a shift write is due this cycle
        logic out_free;  // result register can take a new beat
    } t_stat;

endpackage

### src/isl_ctrl.sv
// ----------------------------------------------------------------------------
// isl_ctrl: request sequencer
// Steps one request at a time through check, shift, search or read, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module isl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output isl_pkg::t_cmd o_cmd,
    input  isl_pkg::t_stat i_stat
);
    import isl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_SHIFT  = 8'b0000_0100,
        S_PUT    = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_FETCH  = 8'b0010_0000,
        S_GRAB   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_stat.op)
                        OP_INSERT, OP_DELETE: n_state = S_SHIFT;
                        OP_FIND:              n_state = S_SCAN;
                        OP_READ:              n_state = S_FETCH;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_SHIFT: begin
                o_cmd.step = 1'b1;
                // the last moved word is written in the cycle more drops
                if (!i_stat.more) begin
                    n_state = (i_stat.op == OP_INSERT) ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_DONE;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_DONE;
                end else if (!i_stat.more && !i_stat.rpend) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_GRAB;
            end
            S_GRAB: begin
                o_cmd.grab = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### src/isl_dp.sv
// ----------------------------------------------------------------------------
// isl_dp: list datapath
// Element store with one write and one registered read port, entry count,
// scan index, request registers and the result register.
// ----------------------------------------------------------------------------
module isl_dp #(
    parameter int unsigned CAPACITY = isl_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  isl_pkg::t_cmd               i_cmd,
    output isl_pkg::t_stat              o_stat,
    input  logic [isl_pkg::OP_W-1:0]    i_operation,
    input  logic [isl_pkg::POS_W-1:0]   i_position,
    input  logic signed [isl_pkg::VAL_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [isl_pkg::STAT_W-1:0]  o_status,
    output logic [isl_pkg::POS_W-1:0]   o_found_position,
    output logic signed [isl_pkg::VAL_W-1:0] o_read_value,
    output logic [isl_pkg::LEN_W-1:0]   o_list_length
);
    import isl_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = (CW > POS_W) ? CW : POS_W;

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    t_op              r_op;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_wa;
    logic [AW-1:0]    r_fa;
    logic             r_wpend;
    logic             r_rpend;
    t_status          r_status;
    logic [POS_W-1:0] r_found;
    logic [VAL_W-1:0] r_rdval;

    logic             r_out_vld;
    t_status          r_o_status;
    logic [POS_W-1:0] r_o_found;
    logic [VAL_W-1:0] r_o_rdval;
    logic [LEN_W-1:0] r_o_len;

    logic [EW-1:0]    pos_e;
    logic [EW-1:0]    cnt_e;
    logic [EW-1:0]    idx_e;
    t_status          err_code;
    logic             more;
    logic [CW-1:0]    ra;
    logic             step_rd;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [VAL_W-1:0] mem_wd;
    logic [AW-1:0]    mem_ra;

    assign pos_e = EW'(r_pos);
    assign cnt_e = EW'(r_count);
    assign idx_e = EW'(r_idx);

    always_comb begin
        err_code = ST_OK;
        unique case (r_op)
            OP_INSERT: begin
                if (cnt_e >= EW'(CAPACITY)) begin
                    err_code = ST_FULL;
                end else if (pos_e > cnt_e) begin
                    err_code = ST_BAD_POS;
                end
            end
            OP_DELETE: begin
                if (r_count == '0) begin
                    err_code = ST_EMPTY;
                end else if (pos_e >= cnt_e) begin
                    err_code = ST_BAD_POS;
                end
            end
            OP_READ: begin
                if (pos_e >= cnt_e) begin
                    err_code = ST_BAD_POS;
                end
            end
            default: err_code = ST_OK;
        endcase
    end

    // insert walks down from the end, delete and find walk up
    always_comb begin
        case (r_op)
            OP_INSERT: more = (idx_e > pos_e);
            OP_DELETE: more = (r_idx < r_count);
            OP_FIND:   more = (r_idx < r_count);
            default:   more = 1'b0;
        endcase
    end

    assign ra      = (r_op == OP_INSERT) ? (r_idx - CW'(1)) : r_idx;
    assign step_rd = i_cmd.step && more;

    // element store
    assign mem_we = i_cmd.put || r_wpend;
    assign mem_wa = i_cmd.put ? AW'(r_pos) : r_wa[AW-1:0];
    assign mem_wd = i_cmd.put ? r_val : r_rdata;
    assign mem_ra = i_cmd.fetch ? AW'(r_pos) : ra[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_comb begin
        n_count = r_count;
        if (r_status == ST_OK) begin
            if (r_op == OP_INSERT) begin
                n_count = r_count + CW'(1);
            end else if (r_op == OP_DELETE) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    // request, scan and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_operation);
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.decode) begin
            r_status <= err_code;
            r_found  <= '0;
            r_rdval  <= '0;
            case (r_op)
                OP_INSERT: r_idx <= r_count;
                OP_DELETE: r_idx <= CW'(pos_e + EW'(1));
                default:   r_idx <= '0;
            endcase
        end
        if (step_rd) begin
            r_idx <= (r_op == OP_INSERT) ? (r_idx - CW'(1)) : (r_idx + CW'(1));
            r_wa  <= (r_op == OP_INSERT) ? r_idx : (r_idx - CW'(1));
            r_fa  <= ra[AW-1:0];
        end
        if (i_cmd.hit) begin
            r_found <= POS_W'(r_fa);
        end
        if (i_cmd.miss) begin
            r_status <= ST_NOT_FOUND;
        end
        if (i_cmd.grab) begin
            r_rdval <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_rdval  <= r_rdval;
            r_o_len    <= LEN_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wpend   <= 1'b0;
            r_rpend   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_wpend <= step_rd && (r_op == OP_INSERT || r_op == OP_DELETE);
            r_rpend <= step_rd && (r_op == OP_FIND);
            if (i_cmd.emit) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.err      = (err_code != ST_OK);
    assign o_stat.more     = more;
    assign o_stat.hit      = r_rpend && (r_rdata == r_val);
    assign o_stat.rpend    = r_rpend;
    assign o_stat.wpend    = r_wpend;
    assign o_stat.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_read_value     = r_o_rdval;
    assign o_list_length    = r_o_len;

endmodule

### src/indexed_sequential_list.sv
// ----------------------------------------------------------------------------
// indexed_sequential_list: bounded ordered list of signed 32-bit words
// Insert, delete, find and read requests against a one-read, one-write element
// store, one request in flight, one result beat per request.
//
//   channel   handshake                 payload
//   request   i_in_valid / o_in_ready   i_operation, i_position, i_value
//   result    o_out_valid / i_out_ready o_status, o_found_position,
//                                       o_read_value, o_list_length
//
// Shifts and searches move one word a cycle through the store's one read and
// one write port. Reset clears the count, state and flags; store words are
// undefined until written. A stalled result holds in the output register
// while the next request is taken and worked on up to its own result.
// ----------------------------------------------------------------------------
module indexed_sequential_list #(
    parameter int unsigned CAPACITY = isl_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [isl_pkg::OP_W-1:0]         i_operation,
    input  logic [isl_pkg::POS_W-1:0]        i_position,
    input  logic signed [isl_pkg::VAL_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [isl_pkg::STAT_W-1:0]       o_status,
    output logic [isl_pkg::POS_W-1:0]        o_found_position,
    output logic signed [isl_pkg::VAL_W-1:0] o_read_value,
    output logic [isl_pkg::LEN_W-1:0]        o_list_length
);
    import isl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    isl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    isl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_read_value     (o_read_value),
        .o_list_length    (o_list_length)
    );

    // one request at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in flight");

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.put && stat.wpend))
        else $error("store write port claimed twice");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
            ((o_found_position == '0) && (o_read_value == '0)))
        else $error("failed request carries nonzero data");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_list_length == LEN_W'(CAPACITY)))
        else $error("full status with short list");

endmodule

### tb/indexed_sequential_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequential_list_checker: result scoreboard for the list block
// Watches the request and result channels, keeps its own copy of the list,
// works out the result of every accepted request and compares each result
// beat, field by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module indexed_sequential_list_checker
    import isl_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [POS_W-1:0]  i_position,
    input  logic [VAL_W-1:0]  i_value,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [STAT_W-1:0] i_status,
    input  logic [POS_W-1:0]  i_found_position,
    input  logic [VAL_W-1:0]  i_read_value,
    input  logic [LEN_W-1:0]  i_list_length,
    output int                o_error_count,
    output int                o_pending
);

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   found_at;
        logic [VAL_W-1:0]   word;
        logic [LEN_W-1:0]   length;
    } t_list_result;

    logic [VAL_W-1:0] list_words [CAPACITY];
    int unsigned      list_len;
    t_list_result     list_results [$];
    t_list_result     want;
    int unsigned      result_index;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        list_len      = 0;
        result_index  = 0;
    end

    task automatic log_mismatch(input string msg);
        if (o_error_count < 40) begin
            $display("%0t ns: list check: %s", $time, msg);
        end
        o_error_count++;
    endtask

    // Apply one request to the shadow list and return the result it yields.
    function automatic t_list_result apply_request(input t_op op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VAL_W-1:0] val);
        t_list_result r;
        int           j;
        bit           hit;
        r.status   = ST_OK;
        r.found_at = '0;
        r.word     = '0;
        hit        = 1'b0;
        case (op)
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos > list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (j = list_len; j > pos; j--) begin
                        list_words[j] = list_words[j-1];
                    end
                    list_words[pos] = val;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    // close the gap without touching anything past the tail
                    for (j = pos; j + 1 < list_len; j++) begin
                        list_words[j] = list_words[j+1];
                    end
                    list_len--;
                end
            end
            OP_FIND: begin
                for (j = 0; j < list_len && !hit; j++) begin
                    if (list_words[j] == val) begin
                        hit        = 1'b1;
                        r.found_at = j[POS_W-1:0];
                    end
                end
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (pos >= list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.word = list_words[pos];
                end
            end
        endcase
        r.length = list_len[LEN_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            list_results.delete();
            o_pending = 0;
        end else begin
            // check the result beat first: it always belongs to an older request
            if (i_out_valid && i_out_ready) begin
                if (list_results.size() == 0) begin
                    log_mismatch($sformatf("result beat %0d with no request outstanding",
                                           result_index));
                end else begin
                    want = list_results.pop_front();
                    if (i_status !== want.status) begin
                        log_mismatch($sformatf("beat %0d status %0d, want %0d",
                                               result_index, i_status, want.status));
                    end
                    if (i_found_position !== want.found_at) begin
                        log_mismatch($sformatf("beat %0d found_position %0d, want %0d",
                                               result_index, i_found_position,
                                               want.found_at));
                    end
                    if (i_read_value !== want.word) begin
                        log_mismatch($sformatf("beat %0d read_value %h, want %h",
                                               result_index, i_read_value, want.word));
                    end
                    if (i_list_length !== want.length) begin
                        log_mismatch($sformatf("beat %0d list_length %0d, want %0d",
                                               result_index, i_list_length, want.length));
                    end
                end
                result_index++;
            end
            if (i_in_valid && i_in_ready) begin
                list_results.push_back(apply_request(t_op'(i_operation), i_position,
                                                     i_value));
            end
            o_pending = list_results.size();
        end
    end

endmodule

### tb/indexed_sequential_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequential_list_tb: testbench top for the indexed sequential list
// Drives directed corner requests and then phases of random requests that
// grow the list to full, drain it to empty and mix all operations, under
// changing sender gaps and receiver stalls. The checker does the scoring.
// ----------------------------------------------------------------------------
module indexed_sequential_list_tb;
    import isl_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int LIST_CAP   = CAPACITY_DEF;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 105;
    localparam int TAIL_WAIT  = 200;
    localparam int POOL_SIZE  = 12;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation;
    logic [POS_W-1:0]        i_position;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [STAT_W-1:0]       o_status;
    logic [POS_W-1:0]        o_found_position;
    logic signed [VAL_W-1:0] o_read_value;
    logic [LEN_W-1:0]        o_list_length;

    int error_count;
    int pending_count;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int len_track       = 0;

    logic signed [VAL_W-1:0] value_pool [POOL_SIZE];

    indexed_sequential_list uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_read_value     (o_read_value),
        .o_list_length    (o_list_length)
    );

    indexed_sequential_list_checker #(.CAPACITY(LIST_CAP)) list_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_found_position (o_found_position),
        .i_read_value     (o_read_value),
        .i_list_length    (o_list_length),
        .o_error_count    (error_count),
        .o_pending        (pending_count)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // Send one request beat; called and returns at a falling edge.
    task automatic issue_request(input t_op op, input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        // track the length so positions can be aimed at the live range
        if (op == OP_INSERT && len_track < LIST_CAP && pos <= len_track) begin
            len_track++;
        end else if (op == OP_DELETE && len_track > 0 && pos < len_track) begin
            len_track--;
        end
    endtask

    // Hold the request channel idle until every result beat has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
    endtask

    initial begin
        int   phase;
        int   n;
        int   roll;
        int   ins_pct;
        int   del_pct;
        int   find_pct;
        t_op  op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_INSERT;
        i_position  = '0;
        i_value     = '0;
        i_out_ready = 1'b0;

        value_pool[0] = 32'sd0;
        value_pool[1] = -32'sd1;
        value_pool[2] = 32'sd100;
        value_pool[3] = 32'h7FFF_FFFF;
        value_pool[4] = 32'h8000_0000;
        for (n = 5; n < POOL_SIZE; n++) begin
            value_pool[n] = $urandom();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corners on an empty list
        issue_request(OP_READ,   7'd0,   32'sd0);
        issue_request(OP_DELETE, 7'd0,   32'sd0);
        issue_request(OP_FIND,   7'd0,   -32'sd1);
        issue_request(OP_INSERT, 7'd1,   32'sd5);
        // build a short list with duplicates and extreme words
        issue_request(OP_INSERT, 7'd0,   32'h7FFF_FFFF);
        issue_request(OP_INSERT, 7'd1,   32'h8000_0000);
        issue_request(OP_INSERT, 7'd0,   -32'sd1);
        issue_request(OP_INSERT, 7'd1,   32'sd0);
        issue_request(OP_INSERT, 7'd2,   -32'sd1);
        issue_request(OP_FIND,   7'd127, -32'sd1);
        issue_request(OP_FIND,   7'd0,   32'h8000_0000);
        issue_request(OP_FIND,   7'd0,   32'sd100);
        issue_request(OP_READ,   7'd0,   32'sd0);
        issue_request(OP_READ,   7'd4,   -32'sd1);
        issue_request(OP_READ,   7'd5,   32'sd0);
        issue_request(OP_READ,   7'd127, 32'sd0);
        issue_request(OP_INSERT, 7'd127, 32'sd7);
        issue_request(OP_DELETE, 7'd5,   32'sd0);
        issue_request(OP_DELETE, 7'd127, 32'sd0);
        // tail, head, then middle
        issue_request(OP_DELETE, 7'd4,   32'sd0);
        issue_request(OP_DELETE, 7'd0,   32'sd0);
        issue_request(OP_DELETE, 7'd1,   32'sd0);
        issue_request(OP_READ,   7'd1,   32'sd0);
        drain_results();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin sender_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            // two growing phases fill the list, two shrinking ones empty it
            case (phase % 5)
                0, 1: begin ins_pct = 80; del_pct = 5;  find_pct = 8;  end
                2:    begin ins_pct = 30; del_pct = 25; find_pct = 25; end
                default: begin ins_pct = 5; del_pct = 80; find_pct = 8; end
            endcase
            for (n = 0; n < PHASE_LEN; n++) begin
                roll = $urandom_range(99);
                op = (roll < ins_pct)                     ? OP_INSERT :
                     (roll < ins_pct + del_pct)           ? OP_DELETE :
                     (roll < ins_pct + del_pct + find_pct) ? OP_FIND   : OP_READ;
                if ($urandom_range(9) == 0 || op == OP_FIND) begin
                    pos = POS_W'($urandom_range(127));
                end else if (op == OP_INSERT) begin
                    pos = POS_W'($urandom_range((len_track > 127) ? 127 : len_track));
                end else begin
                    pos = (len_track == 0) ? 7'd0
                                           : POS_W'($urandom_range(len_track - 1));
                end
                val = ($urandom_range(99) < 65) ? value_pool[$urandom_range(POOL_SIZE-1)]
                                                : $urandom();
                issue_request(op, pos, val);
            end
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
